[rtl/pwc_pkg.sv]
package pwc_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int PIN_COUNT    = 8;
  localparam int CH_W         = 3;
  localparam int ACTIVE_W     = 4;
  localparam int COUNT_W      = 16;
  localparam int DUR_W        = 32;
  localparam int CFG_DATA_W   = 4;
  localparam int CFG_INDEX_W  = 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_CHANNELS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_ENABLE  = 1'd1;

  localparam logic RESULT_DONE = 1'b0;
  localparam logic RESULT_READ = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_READ    = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_CAPTURE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [COUNT_W-1:0]  count;
    logic                found;
    logic [CH_W-1:0]     scan_ch;
    logic [CH_W-1:0]     read_ch;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/pwc_sample_if.sv]
interface pwc_sample_if;
  import pwc_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [COUNT_W-1:0] capture_count;
  logic [PIN_COUNT-1:0] pin_levels;
  logic [CH_W-1:0]    read_channel;

  modport source (output valid, operation, capture_count, pin_levels, read_channel,
                  input ready);
  modport sink   (input valid, operation, capture_count, pin_levels, read_channel,
                  output ready);
endinterface

[rtl/pwc_report_if.sv]
interface pwc_report_if;
  import pwc_pkg::*;

  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [CH_W-1:0]  channel;
  logic [DUR_W-1:0] duration_ticks;
  logic             fresh;

  modport source (output valid, result_kind, channel, duration_ticks, fresh,
                  input ready);
  modport sink   (input valid, result_kind, channel, duration_ticks, fresh,
                  output ready);
endinterface

[rtl/pwc_front.sv]
module pwc_front
  import pwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  pwc_sample_if.sink             sample,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  queue_status_t          qstat,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic [ACTIVE_W-1:0]  active_channels;
  logic                 capture_enable;
  logic [ACTIVE_W-1:0]  limit;
  logic [PIN_COUNT-1:0] scan_mask;
  logic                 found;
  logic [CH_W-1:0]      scan_ch;
  op_t                  op;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= '0;
      capture_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_CHANNELS: active_channels <= cfg_data[ACTIVE_W-1:0];
        CFG_CAPTURE_ENABLE:  capture_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // scan covers min(active_channels, channel count, pin count)
  always_comb begin
    limit = active_channels;
    if (limit > ACTIVE_W'(NUM_CHANNELS)) limit = ACTIVE_W'(NUM_CHANNELS);
    if (limit > ACTIVE_W'(PIN_COUNT))    limit = ACTIVE_W'(PIN_COUNT);
    for (int i = 0; i < PIN_COUNT; i++) begin
      scan_mask[i] = (ACTIVE_W'(i) < limit);
    end
  end

  // lowest high pin wins
  always_comb begin
    found   = 1'b0;
    scan_ch = '0;
    for (int i = PIN_COUNT - 1; i >= 0; i--) begin
      if (sample.pin_levels[i] && scan_mask[i]) begin
        found   = 1'b1;
        scan_ch = CH_W'(i);
      end
    end
  end

  assign op           = op_t'(sample.operation);
  assign sample.ready = !qstat.full;

  always_comb begin
    push_cmd.kind    = CMD_TICK;
    push_cmd.count   = sample.capture_count;
    push_cmd.found   = found;
    push_cmd.scan_ch = scan_ch;
    push_cmd.read_ch = sample.read_channel;
    push             = 1'b0;
    unique case (op)
      OP_TICK: begin
        push_cmd.kind = CMD_TICK;
        push          = 1'b1;
      end
      OP_CAPTURE: begin
        push_cmd.kind = CMD_CAPTURE;
        push          = capture_enable;
      end
      OP_READ: begin
        push_cmd.kind = CMD_READ;
        push          = 1'b1;
      end
      default: ;
    endcase
    push = push && sample.valid && sample.ready;
  end

endmodule

[rtl/pwc_queue.sv]
module pwc_queue
  import pwc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t qstat
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  assign head        = slots[rd_ptr];
  assign qstat.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);

endmodule

[rtl/pwc_back.sv]
module pwc_back
  import pwc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          head,
  input  queue_status_t qstat,
  output logic          pop,
  pwc_report_if.source  report
);

  logic [COUNT_W-1:0] overflow_count;
  logic               awaiting_fall;
  logic [CH_W-1:0]    measuring_channel;
  logic [DUR_W-1:0]   start_stamp   [NUM_CHANNELS];
  logic [DUR_W-1:0]   held_duration [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] fresh_marks;

  logic             out_valid;
  logic             out_kind;
  logic [CH_W-1:0]  out_channel;
  logic [DUR_W-1:0] out_duration;
  logic             out_fresh;

  logic             read_in_range;
  logic [DUR_W-1:0] stamp;
  logic [DUR_W-1:0] duration;
  logic             emit;

  // next command goes once the output register is free or being drained
  assign pop = !qstat.empty && (!out_valid || report.ready);

  assign stamp         = {overflow_count, head.count};
  assign duration      = stamp - start_stamp[measuring_channel];
  assign read_in_range = ({1'b0, head.read_ch} < (CH_W+1)'(NUM_CHANNELS));

  // a falling edge or a read leaves a result beat
  assign emit = pop && ((head.kind == CMD_CAPTURE && awaiting_fall) ||
                        head.kind == CMD_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count    <= '0;
      awaiting_fall     <= 1'b0;
      measuring_channel <= '0;
      fresh_marks       <= '0;
      out_valid         <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) held_duration[i] <= '0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (report.ready) out_valid <= 1'b0;
      if (pop) begin
        unique case (head.kind)
          CMD_TICK: begin
            overflow_count <= overflow_count + 1'b1;
          end
          CMD_CAPTURE: begin
            if (awaiting_fall) begin
              held_duration[measuring_channel] <= duration;
              fresh_marks[measuring_channel]   <= 1'b1;
              awaiting_fall                    <= 1'b0;
            end else if (head.found) begin
              measuring_channel <= head.scan_ch;
              awaiting_fall     <= 1'b1;
            end
          end
          CMD_READ: begin
            if (read_in_range) fresh_marks[head.read_ch] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload and stamps carry no reset
  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_CAPTURE) begin
      if (awaiting_fall) begin
        out_kind     <= RESULT_DONE;
        out_channel  <= measuring_channel;
        out_duration <= duration;
        out_fresh    <= 1'b1;
      end else if (head.found) begin
        start_stamp[head.scan_ch] <= stamp;
      end
    end else if (pop && head.kind == CMD_READ) begin
      out_kind    <= RESULT_READ;
      out_channel <= head.read_ch;
      if (read_in_range) begin
        out_duration <= held_duration[head.read_ch];
        out_fresh    <= fresh_marks[head.read_ch];
      end else begin
        out_duration <= '0;
        out_fresh    <= 1'b0;
      end
    end
  end

  assign report.valid          = out_valid;
  assign report.result_kind    = out_kind;
  assign report.channel        = out_channel;
  assign report.duration_ticks = out_duration;
  assign report.fresh          = out_fresh;

endmodule

[rtl/multichannel_pulse_width_capture_unit.sv]
// a beat passes the command queue, then the result register that drives report
// throughput: one beat per cycle, held up only when the 4-entry command queue fills
// while the result register waits on report.ready
// reset (synchronous, active high) empties the queue, clears timer extension, mode,
// durations and fresh marks, and sets active_channels 0 and capture_enable 1
module multichannel_pulse_width_capture_unit
  import pwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  pwc_sample_if.sink             sample,
  pwc_report_if.source           report,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  queue_status_t qstat;
  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;

  pwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pwc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  pwc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .report (report)
  );

endmodule

[verif/multichannel_pulse_width_capture_unit_tb.sv]
`timescale 1ns / 1ps

module multichannel_pulse_width_capture_unit_tb;
  import pwc_pkg::*;

  typedef struct packed {
    op_t                  op;
    logic [COUNT_W-1:0]   count;
    logic [PIN_COUNT-1:0] pins;
    logic [CH_W-1:0]      rch;
  } sample_t;

  typedef struct packed {
    logic             kind;
    logic [CH_W-1:0]  ch;
    logic [DUR_W-1:0] dur;
    logic             fresh;
  } report_t;

  class pulse_scoreboard;
    report_t            pending_reports[$];
    logic [15:0]        overflow_count;
    logic               awaiting_fall;
    logic [CH_W-1:0]    measuring_ch;
    logic [DUR_W-1:0]   start_stamp[NUM_CHANNELS];
    logic [DUR_W-1:0]   held_duration[NUM_CHANNELS];
    logic               fresh_mark[NUM_CHANNELS];
    logic [ACTIVE_W-1:0] active_channels;
    logic               capture_on;
    int                 errors;
    int                 samples_noted;
    int                 completions_seen;
    int                 answers_seen;

    function new();
      overflow_count  = '0;
      awaiting_fall   = 1'b0;
      measuring_ch    = '0;
      active_channels = '0;
      capture_on      = 1'b1;
      foreach (held_duration[i]) begin
        start_stamp[i]   = '0;
        held_duration[i] = '0;
        fresh_mark[i]    = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ACTIVE_CHANNELS) begin
        active_channels = data[ACTIVE_W-1:0];
      end else if (idx == CFG_CAPTURE_ENABLE) begin
        capture_on = data[0];
      end
    endfunction

    // works out the report, if any, that an accepted beat causes
    function void note_sample(sample_t s);
      int               scan_limit;
      bit               found;
      logic [DUR_W-1:0] stamp;
      report_t          r;
      samples_noted++;
      stamp = {overflow_count, s.count};
      case (s.op)
        OP_TICK: begin
          overflow_count = overflow_count + 16'd1;
        end
        OP_CAPTURE: begin
          if (capture_on) begin
            if (awaiting_fall) begin
              r.kind  = RESULT_DONE;
              r.ch    = measuring_ch;
              r.dur   = stamp - start_stamp[measuring_ch];
              r.fresh = 1'b1;
              held_duration[measuring_ch] = r.dur;
              fresh_mark[measuring_ch]    = 1'b1;
              awaiting_fall = 1'b0;
              pending_reports.push_back(r);
            end else begin
              scan_limit = int'(active_channels);
              if (scan_limit > NUM_CHANNELS) scan_limit = NUM_CHANNELS;
              if (scan_limit > PIN_COUNT) scan_limit = PIN_COUNT;
              found = 1'b0;
              for (int i = 0; i < scan_limit; i++) begin
                if (!found && s.pins[i]) begin
                  found          = 1'b1;
                  measuring_ch   = CH_W'(i);
                  start_stamp[i] = stamp;
                  awaiting_fall  = 1'b1;
                end
              end
            end
          end
        end
        OP_READ: begin
          r.kind = RESULT_READ;
          r.ch   = s.rch;
          if (int'(s.rch) < NUM_CHANNELS) begin
            r.dur   = held_duration[s.rch];
            r.fresh = fresh_mark[s.rch];
            fresh_mark[s.rch] = 1'b0;
          end else begin
            r.dur   = '0;
            r.fresh = 1'b0;
          end
          pending_reports.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: stray report kind %0d ch %0d dur %08h fresh %0d", $realtime,
                   got.kind, got.ch, got.dur, got.fresh);
        return;
      end
      want = pending_reports.pop_front();
      if (got.kind == RESULT_DONE) completions_seen++;
      else answers_seen++;
      if (got.kind !== want.kind || got.ch !== want.ch || got.dur !== want.dur ||
          got.fresh !== want.fresh) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: report mismatch: expected kind %0d ch %0d dur %08h fresh %0d,",
                   $realtime, want.kind, want.ch, want.dur, want.fresh);
          $display("  got kind %0d ch %0d dur %08h fresh %0d",
                   got.kind, got.ch, got.dur, got.fresh);
        end
      end
    endfunction

    function int failures();
      if (pending_reports.size() != 0)
        $display("%0d expected reports never arrived", pending_reports.size());
      return errors + pending_reports.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pwc_sample_if sample_bus();
  pwc_report_if report_bus();

  multichannel_pulse_width_capture_unit dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_bus),
    .report    (report_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pulse_scoreboard sb;
  bit send_burst;
  int input_stall_cycles;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic sample_t pack_sample(op_t op, logic [COUNT_W-1:0] count,
                                          logic [PIN_COUNT-1:0] pins, logic [CH_W-1:0] rch);
    sample_t s;
    s.op    = op;
    s.count = count;
    s.pins  = pins;
    s.rch   = rch;
    return s;
  endfunction

  function automatic int next_gap();
    return send_burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    int      shape;
    s.count = COUNT_W'($urandom_range(0, 65535));
    s.pins  = PIN_COUNT'($urandom_range(0, 255));
    s.rch   = CH_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 22) s.op = OP_TICK;
    else if (pick < 64) s.op = OP_CAPTURE;
    else if (pick < 94) s.op = OP_READ;
    else s.op = OP_UNUSED;
    shape = $urandom_range(0, 9);
    if (shape == 0) s.pins = '0;
    else if (shape < 3) s.pins = PIN_COUNT'(1) << $urandom_range(0, PIN_COUNT - 1);
    shape = $urandom_range(0, 9);
    if (shape == 0) s.count = '0;
    else if (shape == 1) s.count = '1;
    return s;
  endfunction

  // valid stays up across back-to-back beats, dropped only for a gap
  task automatic send_item(input sample_t s, input int gap);
    repeat (gap) begin
      @(negedge clk);
      sample_bus.valid = 1'b0;
    end
    @(negedge clk);
    sample_bus.valid         = 1'b1;
    sample_bus.operation     = s.op;
    sample_bus.capture_count = s.count;
    sample_bus.pin_levels    = s.pins;
    sample_bus.read_channel  = s.rch;
    @(posedge clk);
    while (!sample_bus.ready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    sb.note_sample(s);
  endtask

  task automatic drain_reports();
    @(negedge clk);
    sample_bus.valid = 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    // ticks and ignored beats may still sit in the command queue
    repeat (16) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    settings_used++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random stalls, bursts of no stall, and two long hold-offs
  initial begin
    int      stall;
    int      beats;
    bit      recv_burst;
    report_t got;
    beats = 0;
    recv_burst = 1'b0;
    report_bus.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (beats % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (beats == 150 || beats == 450) stall = 400;
      else stall = recv_burst ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        report_bus.ready = 1'b0;
      end
      @(negedge clk);
      report_bus.ready = 1'b1;
      @(posedge clk);
      while (!report_bus.valid) @(posedge clk);
      got.kind  = report_bus.result_kind;
      got.ch    = report_bus.channel;
      got.dur   = report_bus.duration_ticks;
      got.fresh = report_bus.fresh;
      sb.check_report(got);
      beats++;
    end
  end

  initial begin
    int          phase_active[11] = '{0, 15, 3, 1, 8, 9, 5, 7, 2, 4, 8};
    bit          phase_enable[11] = '{1, 1, 1, 1, 0, 1, 1, 1, 0, 1, 1};
    int          wait_cycles;
    sample_t     directed[$];

    sb = new();
    send_burst = 1'b0;
    input_stall_cycles = 0;
    settings_used = 0;
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = '0;
    cfg_data                 = '0;
    sample_bus.valid         = 1'b0;
    sample_bus.operation     = OP_TICK;
    sample_bus.capture_count = '0;
    sample_bus.pin_levels    = '0;
    sample_bus.read_channel  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset leaves no channel scanned, so this edge latches nothing
    send_item(pack_sample(OP_CAPTURE, 16'h1234, 8'hFF, 3'd0), next_gap());
    send_item(pack_sample(OP_READ, 16'h0000, 8'h00, 3'd0), next_gap());
    drain_reports();
    set_register(CFG_ACTIVE_CHANNELS, CFG_DATA_W'(8));

    directed = '{
      pack_sample(OP_TICK,    16'h0000, 8'h00, 3'd0),
      pack_sample(OP_CAPTURE, 16'h1111, 8'h00, 3'd0),
      pack_sample(OP_CAPTURE, 16'hFFFF, 8'h80, 3'd0),
      pack_sample(OP_TICK,    16'h0000, 8'h00, 3'd0),
      pack_sample(OP_UNUSED,  16'hFFFF, 8'hFF, 3'd7),
      pack_sample(OP_CAPTURE, 16'h0000, 8'hFF, 3'd0),
      pack_sample(OP_READ,    16'h0000, 8'h00, 3'd7),
      pack_sample(OP_READ,    16'hFFFF, 8'hFF, 3'd7),
      pack_sample(OP_CAPTURE, 16'h0000, 8'hFF, 3'd0),
      pack_sample(OP_CAPTURE, 16'hFFFF, 8'h00, 3'd0),
      pack_sample(OP_CAPTURE, 16'h8000, 8'h06, 3'd0),
      pack_sample(OP_CAPTURE, 16'h7FFF, 8'hFF, 3'd0),
      pack_sample(OP_READ,    16'h0000, 8'h00, 3'd1),
      pack_sample(OP_READ,    16'h0000, 8'h00, 3'd0),
      pack_sample(OP_READ,    16'h0000, 8'h00, 3'd3),
      pack_sample(OP_CAPTURE, 16'h0005, 8'h40, 3'd0),
      pack_sample(OP_CAPTURE, 16'h0005, 8'h00, 3'd0),
      pack_sample(OP_READ,    16'h0000, 8'h00, 3'd6),
      pack_sample(OP_CAPTURE, 16'd100,  8'h10, 3'd0)
    };
    foreach (directed[i]) send_item(directed[i], next_gap());

    // a disabled capture must keep the pending fall on channel 4
    drain_reports();
    set_register(CFG_CAPTURE_ENABLE, CFG_DATA_W'(0));
    send_item(pack_sample(OP_CAPTURE, 16'd200, 8'hFF, 3'd0), next_gap());
    send_item(pack_sample(OP_READ, 16'd0, 8'h00, 3'd4), next_gap());
    drain_reports();
    set_register(CFG_CAPTURE_ENABLE, CFG_DATA_W'(1));
    send_item(pack_sample(OP_CAPTURE, 16'd300, 8'h00, 3'd0), next_gap());
    send_item(pack_sample(OP_READ, 16'd0, 8'h00, 3'd4), next_gap());

    foreach (phase_active[p]) begin
      drain_reports();
      set_register(CFG_ACTIVE_CHANNELS, CFG_DATA_W'(phase_active[p]));
      set_register(CFG_CAPTURE_ENABLE, CFG_DATA_W'(phase_enable[p]));
      for (int n = 0; n < 115; n++) begin
        if (n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
        send_item(random_sample(), next_gap());
      end
    end

    // a pulse across a few overflows that ends at a lower count than it began
    send_burst = 1'b1;
    if (sb.awaiting_fall)
      send_item(pack_sample(OP_CAPTURE, 16'h0000, 8'h00, 3'd0), 0);
    send_item(pack_sample(OP_CAPTURE, 16'hABCD, 8'h20, 3'd0), 0);
    for (int n = 0; n < 3; n++)
      send_item(pack_sample(OP_TICK, 16'h0000, 8'h00, 3'd0), 0);
    send_item(pack_sample(OP_CAPTURE, 16'h0005, 8'h00, 3'd0), 0);
    send_item(pack_sample(OP_READ, 16'h0000, 8'h00, 3'd5), 0);

    @(negedge clk);
    sample_bus.valid = 1'b0;
    wait_cycles = 0;
    while (sb.pending_reports.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (16) @(posedge clk);

    $display("covered %0d input beats over %0d register writes: %0d completions,",
             sb.samples_noted, settings_used, sb.completions_seen);
    $display("%0d read answers; input held off for %0d cycles while reports backed up",
             sb.answers_seen, input_stall_cycles);
    if (sb.failures() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/pwc_pkg.sv
rtl/pwc_sample_if.sv
rtl/pwc_report_if.sv
rtl/pwc_front.sv
rtl/pwc_queue.sv
rtl/pwc_back.sv
rtl/multichannel_pulse_width_capture_unit.sv
verif/multichannel_pulse_width_capture_unit_tb.sv
